/* hw/rtl/chg_pkg.sv */
// Package of shared constants, state codes and status types for the convex hull block.
`timescale 1ns / 1ps

package chg_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned IO_COORD_BITS  = 16;

  typedef enum logic [4:0] {
    S_LOAD,
    S_PV_RD,
    S_PV_CMP,
    S_SW_RD,
    S_SW_W0,
    S_SW_W1,
    S_SO_RDT,
    S_SO_LDT,
    S_SO_CHK,
    S_SO_LDQ,
    S_SO_GO,
    S_SO_CR,
    S_SO_DI,
    S_RE_INIT,
    S_RE_LDC,
    S_RE_CHK,
    S_RE_LDN,
    S_RE_GO,
    S_RE_WT,
    S_RE_END,
    S_DEG,
    S_SC_R0,
    S_SC_R1,
    S_SC_R2,
    S_SC_L2,
    S_SC_CHK,
    S_SC_LDC,
    S_SC_LOOP,
    S_SC_WT,
    S_SC_LDN,
    S_EM_RD,
    S_EM_LD
  } chg_state_t;

  // Status of the shared product unit.
  typedef struct packed {
    logic done;
    logic neg;
    logic zero;
  } chg_res_t;

endpackage

/* hw/rtl/chg_if.sv */
// Valid/ready channel interfaces for point words and hull vertex words.
`timescale 1ns / 1ps

interface chg_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [chg_pkg::IO_COORD_BITS-1:0] point_x;
  logic signed [chg_pkg::IO_COORD_BITS-1:0] point_y;
  logic                                   set_end;

  modport source (output valid, output point_x, output point_y, output set_end,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input set_end,
                output ready);
endinterface

interface chg_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [chg_pkg::IO_COORD_BITS-1:0] vertex_x;
  logic signed [chg_pkg::IO_COORD_BITS-1:0] vertex_y;
  logic                                   hull_found;
  logic                                   points_dropped;
  logic                                   final_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output hull_found,
                  output points_dropped, output final_vertex, input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input hull_found,
                input points_dropped, input final_vertex, output ready);
endinterface

/* hw/rtl/convex_hull_graham_scan.sv */
// Top level: Graham-scan convex hull over points held in on-chip memories.
// Points are taken one word per cycle while the block is in point intake; after the final word
// the pivot search, insertion sort, angle reduction and stack scan run sequentially, and the
// sort dominates. Each hull vertex then leaves through a read and a load state, and waits
// while the output still holds the last word.
// Synchronous active-low reset returns the block to point intake with an empty set.
`timescale 1ns / 1ps

module convex_hull_graham_scan #(
  parameter int unsigned MAX_POINTS = chg_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = chg_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  chg_in_if.sink    in_ch,
  chg_out_if.source out_ch
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned D  = C + 1;
  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned IOB = chg_pkg::IO_COORD_BITS;

  chg_pkg::chg_state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, i_r, j_r, m_r, depth_r;
  logic          ovf_r;
  logic [IW-1:0] best_r;

  logic signed [C-1:0] piv_x_r, piv_y_r, t_x_r, t_y_r, q_x_r, q_y_r;
  logic signed [C-1:0] cur_x_r, cur_y_r, nx_x_r, nx_y_r;
  logic signed [C-1:0] top_x_r, top_y_r, nxt_x_r, nxt_y_r;

  logic signed [C-1:0] out_x_r, out_y_r;
  logic                out_vld_r, out_found_r, out_drop_r, out_fin_r;

  // Memories
  logic [2*C-1:0] pmem [MAX_POINTS];
  logic [2*C-1:0] smem [MAX_POINTS];
  logic [2*C-1:0] pm_rd_r, sk_rd_r, pm_wd, sk_wd;
  logic [IW-1:0]  pm_ra, pm_wa, sk_ra, sk_wa;
  logic           pm_we, sk_we;

  logic signed [C-1:0] rd_x, rd_y, sk_x, sk_y, in_x, in_y;
  assign rd_x = pm_rd_r[2*C-1:C];
  assign rd_y = pm_rd_r[C-1:0];
  assign sk_x = sk_rd_r[2*C-1:C];
  assign sk_y = sk_rd_r[C-1:0];

  generate
    if (C > IOB) begin : g_in_wide
      assign in_x = {{(C-IOB){1'b0}}, in_ch.point_x};
      assign in_y = {{(C-IOB){1'b0}}, in_ch.point_y};
    end else begin : g_in_narrow
      assign in_x = in_ch.point_x[C-1:0];
      assign in_y = in_ch.point_y[C-1:0];
    end
    if (C >= IOB) begin : g_out_wide
      assign out_ch.vertex_x = out_x_r[IOB-1:0];
      assign out_ch.vertex_y = out_y_r[IOB-1:0];
    end else begin : g_out_narrow
      assign out_ch.vertex_x = {{(IOB-C){out_x_r[C-1]}}, out_x_r};
      assign out_ch.vertex_y = {{(IOB-C){out_y_r[C-1]}}, out_y_r};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pmem[pm_wa] <= pm_wd;
    end
    pm_rd_r <= pmem[pm_ra];
  end

  always_ff @(posedge clk) begin
    if (sk_we) begin
      smem[sk_wa] <= sk_wd;
    end
    sk_rd_r <= smem[sk_ra];
  end

  // Product unit
  logic                 u_start;
  logic signed [D-1:0]  opa [4];
  logic signed [D-1:0]  opb [4];
  chg_pkg::chg_res_t    ures;

  chg_dot4 #(.COORD_BITS(COORD_BITS)) u_dot (
    .clk   (clk),
    .rst_n (rst_n),
    .start (u_start),
    .opa   (opa),
    .opb   (opb),
    .res   (ures)
  );

  function automatic logic signed [D-1:0] df(logic signed [C-1:0] a,
                                             logic signed [C-1:0] b);
    return $signed({a[C-1], a}) - $signed({b[C-1], b});
  endfunction

  logic in_fire, out_fire, pv_less, so_dec, so_after, sc_push, sc_pop, finish;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_vld_r && out_ch.ready;
  assign pv_less  = (rd_y < piv_y_r) || ((rd_y == piv_y_r) && (rd_x < piv_x_r));

  // Sort decision: a cross product that is not zero settles it, else the distances do.
  always_comb begin
    so_dec   = 1'b0;
    so_after = 1'b0;
    if (state_r == chg_pkg::S_SO_CR && ures.done && !ures.zero) begin
      so_dec   = 1'b1;
      so_after = ures.neg;
    end else if (state_r == chg_pkg::S_SO_DI && ures.done) begin
      so_dec   = 1'b1;
      so_after = !ures.neg && !ures.zero;
    end
  end

  assign sc_push = (state_r == chg_pkg::S_SC_LOOP && depth_r <= CW'(1)) ||
                   (state_r == chg_pkg::S_SC_WT && ures.done && !ures.neg && !ures.zero);
  assign sc_pop  = state_r == chg_pkg::S_SC_WT && ures.done && (ures.neg || ures.zero);
  assign finish  = (state_r == chg_pkg::S_DEG && !out_vld_r) ||
                   (state_r == chg_pkg::S_EM_LD && depth_r == CW'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      chg_pkg::S_LOAD:    if (in_fire && in_ch.set_end) state_nxt = chg_pkg::S_PV_RD;
      chg_pkg::S_PV_RD:   state_nxt = chg_pkg::S_PV_CMP;
      chg_pkg::S_PV_CMP:  state_nxt = (i_r + CW'(1) == cnt_r) ? chg_pkg::S_SW_RD
                                                              : chg_pkg::S_PV_RD;
      chg_pkg::S_SW_RD:   state_nxt = chg_pkg::S_SW_W0;
      chg_pkg::S_SW_W0:   state_nxt = chg_pkg::S_SW_W1;
      chg_pkg::S_SW_W1:   state_nxt = (cnt_r > CW'(2)) ? chg_pkg::S_SO_RDT
                                                       : chg_pkg::S_RE_INIT;
      chg_pkg::S_SO_RDT:  state_nxt = chg_pkg::S_SO_LDT;
      chg_pkg::S_SO_LDT:  state_nxt = chg_pkg::S_SO_CHK;
      chg_pkg::S_SO_CHK: begin
        if (j_r > CW'(1)) state_nxt = chg_pkg::S_SO_LDQ;
        else state_nxt = (i_r + CW'(1) < cnt_r) ? chg_pkg::S_SO_RDT : chg_pkg::S_RE_INIT;
      end
      chg_pkg::S_SO_LDQ:  state_nxt = chg_pkg::S_SO_GO;
      chg_pkg::S_SO_GO:   state_nxt = chg_pkg::S_SO_CR;
      chg_pkg::S_SO_CR, chg_pkg::S_SO_DI: begin
        if (state_r == chg_pkg::S_SO_CR && ures.done && ures.zero) begin
          state_nxt = chg_pkg::S_SO_DI;
        end else if (so_dec) begin
          if (so_after) state_nxt = chg_pkg::S_SO_CHK;
          else state_nxt = (i_r + CW'(1) < cnt_r) ? chg_pkg::S_SO_RDT
                                                  : chg_pkg::S_RE_INIT;
        end
      end
      chg_pkg::S_RE_INIT: state_nxt = (cnt_r > CW'(1)) ? chg_pkg::S_RE_LDC
                                                       : chg_pkg::S_RE_END;
      chg_pkg::S_RE_LDC:  state_nxt = chg_pkg::S_RE_CHK;
      chg_pkg::S_RE_CHK:  state_nxt = (i_r + CW'(1) < cnt_r) ? chg_pkg::S_RE_LDN
                                                             : chg_pkg::S_RE_END;
      chg_pkg::S_RE_LDN:  state_nxt = chg_pkg::S_RE_GO;
      chg_pkg::S_RE_GO:   state_nxt = chg_pkg::S_RE_WT;
      chg_pkg::S_RE_WT:   if (ures.done) state_nxt = chg_pkg::S_RE_CHK;
      chg_pkg::S_RE_END:  state_nxt = (m_r < CW'(3)) ? chg_pkg::S_DEG : chg_pkg::S_SC_R0;
      chg_pkg::S_DEG:     if (!out_vld_r) state_nxt = chg_pkg::S_LOAD;
      chg_pkg::S_SC_R0:   state_nxt = chg_pkg::S_SC_R1;
      chg_pkg::S_SC_R1:   state_nxt = chg_pkg::S_SC_R2;
      chg_pkg::S_SC_R2:   state_nxt = chg_pkg::S_SC_L2;
      chg_pkg::S_SC_L2:   state_nxt = chg_pkg::S_SC_CHK;
      chg_pkg::S_SC_CHK:  state_nxt = (i_r < m_r) ? chg_pkg::S_SC_LDC : chg_pkg::S_EM_RD;
      chg_pkg::S_SC_LDC:  state_nxt = chg_pkg::S_SC_LOOP;
      chg_pkg::S_SC_LOOP: state_nxt = sc_push ? chg_pkg::S_SC_CHK : chg_pkg::S_SC_WT;
      chg_pkg::S_SC_WT: begin
        if (sc_push) state_nxt = chg_pkg::S_SC_CHK;
        else if (sc_pop) state_nxt = (depth_r > CW'(2)) ? chg_pkg::S_SC_LDN
                                                        : chg_pkg::S_SC_LOOP;
      end
      chg_pkg::S_SC_LDN:  state_nxt = chg_pkg::S_SC_LOOP;
      chg_pkg::S_EM_RD:   if (!out_vld_r) state_nxt = chg_pkg::S_EM_LD;
      chg_pkg::S_EM_LD:   state_nxt = (depth_r == CW'(1)) ? chg_pkg::S_LOAD
                                                          : chg_pkg::S_EM_RD;
      default:            state_nxt = chg_pkg::S_LOAD;
    endcase
  end

  // Memory and unit controls
  always_comb begin
    pm_we   = 1'b0;
    pm_wa   = '0;
    pm_wd   = {t_x_r, t_y_r};
    pm_ra   = '0;
    sk_we   = 1'b0;
    sk_wa   = depth_r[IW-1:0];
    sk_wd   = {cur_x_r, cur_y_r};
    sk_ra   = '0;
    u_start = 1'b0;
    for (int k = 0; k < 4; k++) begin
      opa[k] = '0;
      opb[k] = '0;
    end
    case (state_r)
      chg_pkg::S_LOAD: begin
        pm_we = in_fire && (cnt_r < CW'(MAX_POINTS));
        pm_wa = cnt_r[IW-1:0];
        pm_wd = {in_x, in_y};
      end
      chg_pkg::S_PV_RD: pm_ra = i_r[IW-1:0];
      chg_pkg::S_SW_W0: begin
        pm_we = 1'b1;
        pm_wd = {piv_x_r, piv_y_r};
      end
      chg_pkg::S_SW_W1: begin
        pm_we = 1'b1;
        pm_wa = best_r;
      end
      chg_pkg::S_SO_RDT: pm_ra = i_r[IW-1:0];
      chg_pkg::S_SO_CHK: begin
        pm_ra = IW'(j_r - CW'(1));
        if (j_r <= CW'(1)) begin
          pm_we = 1'b1;
          pm_wa = j_r[IW-1:0];
        end
      end
      chg_pkg::S_SO_GO: begin
        u_start = 1'b1;
        opa[0] = df(q_x_r, piv_x_r);
        opb[0] = df(t_y_r, piv_y_r);
        opa[2] = df(q_y_r, piv_y_r);
        opb[2] = df(t_x_r, piv_x_r);
      end
      chg_pkg::S_SO_CR, chg_pkg::S_SO_DI: begin
        // Start the distance comparison when the points are collinear.
        u_start = (state_r == chg_pkg::S_SO_CR) && ures.done && ures.zero;
        opa[0] = df(q_x_r, piv_x_r);
        opb[0] = df(q_x_r, piv_x_r);
        opa[1] = df(q_y_r, piv_y_r);
        opb[1] = df(q_y_r, piv_y_r);
        opa[2] = df(t_x_r, piv_x_r);
        opb[2] = df(t_x_r, piv_x_r);
        opa[3] = df(t_y_r, piv_y_r);
        opb[3] = df(t_y_r, piv_y_r);
        if (so_dec) begin
          pm_we = 1'b1;
          pm_wa = j_r[IW-1:0];
          pm_wd = so_after ? {q_x_r, q_y_r} : {t_x_r, t_y_r};
        end
      end
      chg_pkg::S_RE_INIT: pm_ra = IW'(1);
      chg_pkg::S_RE_CHK: begin
        pm_ra = IW'(i_r + CW'(1));
        pm_wa = m_r[IW-1:0];
        pm_wd = {cur_x_r, cur_y_r};
        pm_we = !(i_r + CW'(1) < cnt_r);
      end
      chg_pkg::S_RE_GO: begin
        u_start = 1'b1;
        opa[0] = df(cur_x_r, piv_x_r);
        opb[0] = df(nx_y_r, piv_y_r);
        opa[2] = df(cur_y_r, piv_y_r);
        opb[2] = df(nx_x_r, piv_x_r);
      end
      chg_pkg::S_RE_WT: begin
        pm_wa = m_r[IW-1:0];
        pm_wd = {cur_x_r, cur_y_r};
        pm_we = ures.done && !ures.zero;
      end
      chg_pkg::S_SC_R0: pm_ra = '0;
      chg_pkg::S_SC_R1: begin
        pm_ra = IW'(1);
        sk_we = 1'b1;
        sk_wa = '0;
        sk_wd = pm_rd_r;
      end
      chg_pkg::S_SC_R2: begin
        pm_ra = IW'(2);
        sk_we = 1'b1;
        sk_wa = IW'(1);
        sk_wd = pm_rd_r;
      end
      chg_pkg::S_SC_L2: begin
        sk_we = 1'b1;
        sk_wa = IW'(2);
        sk_wd = pm_rd_r;
      end
      chg_pkg::S_SC_CHK: pm_ra = i_r[IW-1:0];
      chg_pkg::S_SC_LOOP, chg_pkg::S_SC_WT: begin
        u_start = (state_r == chg_pkg::S_SC_LOOP) && (depth_r > CW'(1));
        opa[0] = df(top_x_r, nxt_x_r);
        opb[0] = df(cur_y_r, nxt_y_r);
        opa[2] = df(top_y_r, nxt_y_r);
        opb[2] = df(cur_x_r, nxt_x_r);
        sk_we  = sc_push;
        sk_ra  = IW'(depth_r - CW'(3));
      end
      chg_pkg::S_EM_RD: sk_ra = IW'(depth_r - CW'(1));
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= chg_pkg::S_LOAD;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
      depth_r   <= '0;
      i_r       <= '0;
      j_r       <= '0;
      m_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_fire) out_vld_r <= 1'b0;
      case (state_r)
        chg_pkg::S_LOAD: begin
          if (in_fire) begin
            if (cnt_r < CW'(MAX_POINTS)) cnt_r <= cnt_r + CW'(1);
            else ovf_r <= 1'b1;
            if (in_ch.set_end) i_r <= '0;
          end
        end
        chg_pkg::S_PV_CMP: i_r <= i_r + CW'(1);
        chg_pkg::S_SW_W1:  i_r <= CW'(2);
        chg_pkg::S_SO_LDT: j_r <= i_r;
        chg_pkg::S_SO_CHK: if (j_r <= CW'(1)) i_r <= i_r + CW'(1);
        chg_pkg::S_SO_CR, chg_pkg::S_SO_DI: begin
          if (so_dec) begin
            if (so_after) j_r <= j_r - CW'(1);
            else i_r <= i_r + CW'(1);
          end
        end
        chg_pkg::S_RE_INIT: begin
          m_r <= CW'(1);
          i_r <= CW'(1);
        end
        chg_pkg::S_RE_CHK: if (!(i_r + CW'(1) < cnt_r)) m_r <= m_r + CW'(1);
        chg_pkg::S_RE_WT: begin
          if (ures.done) begin
            i_r <= i_r + CW'(1);
            if (!ures.zero) m_r <= m_r + CW'(1);
          end
        end
        chg_pkg::S_SC_L2: begin
          depth_r <= CW'(3);
          i_r     <= CW'(3);
        end
        chg_pkg::S_EM_LD: begin
          depth_r   <= depth_r - CW'(1);
          out_vld_r <= 1'b1;
        end
        chg_pkg::S_DEG: if (!out_vld_r) out_vld_r <= 1'b1;
        default: ;
      endcase
      if (sc_push) begin
        depth_r <= depth_r + CW'(1);
        i_r     <= i_r + CW'(1);
      end
      if (sc_pop) depth_r <= depth_r - CW'(1);
      if (finish) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      chg_pkg::S_PV_CMP: begin
        if (i_r == '0 || pv_less) begin
          piv_x_r <= rd_x;
          piv_y_r <= rd_y;
          best_r  <= i_r[IW-1:0];
        end
      end
      chg_pkg::S_SW_W0, chg_pkg::S_SO_LDT: begin
        t_x_r <= rd_x;
        t_y_r <= rd_y;
      end
      chg_pkg::S_SO_LDQ: begin
        q_x_r <= rd_x;
        q_y_r <= rd_y;
      end
      chg_pkg::S_RE_LDC, chg_pkg::S_SC_LDC: begin
        cur_x_r <= rd_x;
        cur_y_r <= rd_y;
      end
      chg_pkg::S_RE_LDN: begin
        nx_x_r <= rd_x;
        nx_y_r <= rd_y;
      end
      chg_pkg::S_RE_WT: begin
        if (ures.done) begin
          cur_x_r <= nx_x_r;
          cur_y_r <= nx_y_r;
        end
      end
      chg_pkg::S_SC_R2: begin
        nxt_x_r <= rd_x;
        nxt_y_r <= rd_y;
      end
      chg_pkg::S_SC_L2: begin
        top_x_r <= rd_x;
        top_y_r <= rd_y;
      end
      chg_pkg::S_SC_LDN: begin
        nxt_x_r <= sk_x;
        nxt_y_r <= sk_y;
      end
      chg_pkg::S_DEG: begin
        if (!out_vld_r) begin
          out_x_r     <= '0;
          out_y_r     <= '0;
          out_found_r <= 1'b0;
          out_drop_r  <= ovf_r;
          out_fin_r   <= 1'b1;
        end
      end
      chg_pkg::S_EM_LD: begin
        out_x_r     <= sk_x;
        out_y_r     <= sk_y;
        out_found_r <= 1'b1;
        out_drop_r  <= ovf_r;
        out_fin_r   <= (depth_r == CW'(1));
      end
      default: ;
    endcase
    if (sc_push) begin
      nxt_x_r <= top_x_r;
      nxt_y_r <= top_y_r;
      top_x_r <= cur_x_r;
      top_y_r <= cur_y_r;
    end
    if (sc_pop) begin
      top_x_r <= nxt_x_r;
      top_y_r <= nxt_y_r;
    end
  end

  assign in_ch.ready           = (state_r == chg_pkg::S_LOAD);
  assign out_ch.valid          = out_vld_r;
  assign out_ch.hull_found     = out_found_r;
  assign out_ch.points_dropped = out_drop_r;
  assign out_ch.final_vertex   = out_fin_r;

  // The product unit only reports a result to a state that is waiting for one.
  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    ures.done |-> (state_r == chg_pkg::S_SO_CR || state_r == chg_pkg::S_SO_DI ||
                   state_r == chg_pkg::S_RE_WT || state_r == chg_pkg::S_SC_WT))
    else $error("product result arrived outside a wait state");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == chg_pkg::S_SC_LOOP) |-> (depth_r >= CW'(1) && depth_r <= m_r))
    else $error("hull stack depth out of range");

  // A new word is never loaded into the output register while one still waits.
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == chg_pkg::S_EM_LD) |-> !out_vld_r)
    else $error("output word overwritten");

endmodule

/* hw/rtl/chg_dot4.sv */
// Shared multiplier unit: sign of a0*b0 + a1*b1 - a2*b2 - a3*b3, from one multiplier used for each product in turn.
`timescale 1ns / 1ps

module chg_dot4 #(
  parameter int unsigned COORD_BITS = chg_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [COORD_BITS:0]  opa [4],
  input  logic signed [COORD_BITS:0]  opb [4],
  output chg_pkg::chg_res_t           res
);

  localparam int unsigned D = COORD_BITS + 1;
  localparam int unsigned P = 2 * D;
  localparam int unsigned A = P + 2;

  logic signed [D-1:0] a_r [4];
  logic signed [D-1:0] b_r [4];
  logic signed [P-1:0] prod_r;
  logic signed [A-1:0] acc_r;
  logic                pvld_r;
  logic                psub_r;
  logic                busy_r;
  logic                done_r;
  logic [2:0]          cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pvld_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 3'd4);
      if (start) begin
        busy_r <= 1'b1;
        pvld_r <= 1'b0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        pvld_r <= (cnt_r < 3'd4);
        cnt_r  <= cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= opa;
      b_r   <= opb;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r < 3'd4) begin
        prod_r <= a_r[cnt_r[1:0]] * b_r[cnt_r[1:0]];
        psub_r <= cnt_r[1];
      end
      if (pvld_r) begin
        acc_r <= psub_r ? acc_r - A'(prod_r) : acc_r + A'(prod_r);
      end
    end
  end

  assign res.done = done_r;
  assign res.neg  = acc_r[A-1];
  assign res.zero = (acc_r == '0);

endmodule
